// ===== sv/ratio_step_line_rasterizer_macros.svh =====
// Assertion macros for the ratio step line rasterizer.
// Expects signals named clk and rst in the scope of each use.
`ifndef RATIO_STEP_LINE_RASTERIZER_MACROS_SVH
`define RATIO_STEP_LINE_RASTERIZER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define RSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define RSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/rsl_pkg.sv =====
// Shared types, constants and the divider interface of the line rasterizer.
// Used by rsl_divider, ratio_step_line_rasterizer and the testbench; depends on nothing.
package rsl_pkg;

  // Frame and coordinate geometry
  localparam int COORD_BITS   = 13;
  localparam int FRAME_WIDTH  = 1920;
  localparam int FRAME_HEIGHT = 1080;
  localparam int INDEX_BITS   = 21;

  // Fixed point scale of the minor over major ratio
  localparam int RATIO_SCALE = 10000;
  localparam int RATIO_BITS  = $clog2(RATIO_SCALE * (2 ** COORD_BITS));

  // Restoring divider: one quotient bit per cycle
  localparam int DIV_STEPS     = RATIO_BITS;
  localparam int STEP_CNT_BITS = $clog2(DIV_STEPS);

  // Signed linear index: row times width plus column
  localparam int LIN_BITS = COORD_BITS + $clog2(FRAME_WIDTH + 1) + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0]        ext_t;
  typedef logic [RATIO_BITS-1:0]        ratio_t;
  typedef logic [INDEX_BITS-1:0]        index_t;
  typedef logic signed [LIN_BITS-1:0]   lin_t;

  // Item modes
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RATIO,
    ST_TEST,
    ST_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic   start;
    ratio_t dividend;
    ext_t   divisor;
  } div_req_t;

  typedef struct packed {
    logic   busy;
    logic   done;
    ratio_t quotient;
  } div_rsp_t;

endpackage

// ===== sv/ratio_step_line_rasterizer.sv =====
// Line segment rasterizer top level: sequencer, cursor registers, output stage.
// Depends on rsl_pkg, rsl_divider and ratio_step_line_rasterizer_macros.svh.
//
// Usage: the input channel (in_valid / in_stall) carries one item. Mode 0
//   loads a segment from start_x/start_y to end_x/end_y and emits the start
//   pixel; mode 1 advances one pixel along the loaded segment. Every item
//   yields exactly one result item on out_valid / out_stall: coordinates,
//   linear index, visibility, valid_pixel and last. An advance with no
//   segment in progress returns an all-zero result.
// Sequence: a single-point load goes from ST_LOAD straight to ST_EMIT; other
//   loads start the 27-step division of minor by major extent in ST_LOAD,
//   wait in ST_RATIO for its done pulse, then emit; an idle advance goes
//   straight to ST_EMIT; an active advance loops through ST_TEST and ST_WAIT,
//   one pass through the shared divider per ratio test, and emits when a
//   ratio test fails or the minor extent is reached.
// Flow: one item at a time; in_stall falls as the result loads, so a new
//   item is taken only once the previous result has loaded.
// Reset and stall: rst (synchronous) drops any segment and clears out_valid.
//   A stalled result holds in the output register; the next item is still
//   accepted, but its result waits until the held one has been taken.
`include "ratio_step_line_rasterizer_macros.svh"

module ratio_step_line_rasterizer import rsl_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_stall,
  input  logic   mode,
  input  coord_t start_x,
  input  coord_t start_y,
  input  coord_t end_x,
  input  coord_t end_y,
  output logic   out_valid,
  input  logic   out_stall,
  output coord_t pixel_x,
  output coord_t pixel_y,
  output index_t pixel_index,
  output logic   visible,
  output logic   valid_pixel,
  output logic   last
);

  function automatic ext_t abs_diff(coord_t a, coord_t b);
    logic signed [COORD_BITS:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    if (d < 0) d = -d;
    return d[COORD_BITS-1:0];
  endfunction

  function automatic coord_t step_toward(coord_t cur, coord_t from, coord_t to);
    coord_t r;
    r = cur;
    if (to > from) r = cur + coord_t'(1);
    else if (to < from) r = cur - coord_t'(1);
    return r;
  endfunction

  state_t   state;
  state_t   state_next;
  coord_t   origin_x, origin_y, target_x, target_y, cursor_x, cursor_y;
  logic     x_is_major;
  ratio_t   segment_ratio;
  logic     segment_active;
  ext_t     minor_ext;
  logic     blank;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic     in_accept;
  logic     emit_go;
  ext_t     ext_x, ext_y, load_major, load_minor;
  logic     load_x_major;
  ext_t     major_trav, minor_trav;
  logic     test_go;
  logic     at_end;
  lin_t     lin;
  logic     lin_visible;

  rsl_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign emit_go   = (state == ST_EMIT) && (!out_valid || !out_stall);

  // Extents of the latched segment
  assign ext_x        = abs_diff(target_x, origin_x);
  assign ext_y        = abs_diff(target_y, origin_y);
  assign load_x_major = ext_x > ext_y;
  assign load_major   = load_x_major ? ext_x : ext_y;
  assign load_minor   = load_x_major ? ext_y : ext_x;

  // Travel so far along each axis
  assign major_trav = x_is_major ? abs_diff(cursor_x, origin_x) : abs_diff(cursor_y, origin_y);
  assign minor_trav = x_is_major ? abs_diff(cursor_y, origin_y) : abs_diff(cursor_x, origin_x);
  assign test_go    = (major_trav != '0) && (minor_trav < minor_ext);
  assign at_end     = (cursor_x == target_x) && (cursor_y == target_y);

  // Linear index and frame bounds
  assign lin         = lin_t'(cursor_y) * lin_t'(FRAME_WIDTH) + lin_t'(cursor_x);
  assign lin_visible = (lin >= 0) && (lin < lin_t'(FRAME_WIDTH * FRAME_HEIGHT));

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state and divider requests
  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = ratio_t'(RATIO_SCALE) * ratio_t'(minor_trav);
    div_req.divisor  = major_trav;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (mode == MODE_LOAD) state_next = ST_LOAD;
          else if (segment_active) state_next = ST_TEST;
          else state_next = ST_EMIT;
        end
      end
      ST_LOAD: begin
        if (load_major == '0) begin
          state_next = ST_EMIT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = ratio_t'(RATIO_SCALE) * ratio_t'(load_minor);
          div_req.divisor  = load_major;
          state_next       = ST_RATIO;
        end
      end
      ST_RATIO: begin
        if (div_rsp.done) state_next = ST_EMIT;
      end
      ST_TEST: begin
        if (test_go) begin
          div_req.start = 1'b1;
          state_next    = ST_WAIT;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_WAIT: begin
        if (div_rsp.done) begin
          state_next = (div_rsp.quotient < segment_ratio) ? ST_TEST : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control flags: segment in progress, blank result
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_active <= 1'b0;
      blank          <= 1'b0;
    end else begin
      if (in_accept) blank <= (mode == MODE_ADVANCE) && !segment_active;
      if (emit_go && !blank) segment_active <= !at_end;
    end
  end

  // Segment and cursor registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (mode == MODE_LOAD) begin
        origin_x <= start_x;
        origin_y <= start_y;
        target_x <= end_x;
        target_y <= end_y;
        cursor_x <= start_x;
        cursor_y <= start_y;
      end else if (segment_active) begin
        // advance the major axis one step toward the end
        if (x_is_major) cursor_x <= step_toward(cursor_x, origin_x, target_x);
        else            cursor_y <= step_toward(cursor_y, origin_y, target_y);
      end
    end
    if (state == ST_LOAD) begin
      x_is_major <= load_x_major;
      minor_ext  <= load_minor;
      if (load_major == '0) segment_ratio <= '0;
    end
    if (state == ST_RATIO && div_rsp.done) segment_ratio <= div_rsp.quotient;
    // step the minor axis while the traveled ratio stays below the segment's
    if (state == ST_WAIT && div_rsp.done && (div_rsp.quotient < segment_ratio)) begin
      if (x_is_major) cursor_y <= step_toward(cursor_y, origin_y, target_y);
      else            cursor_x <= step_toward(cursor_x, origin_x, target_x);
    end
  end

  // Output valid: set on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst)             out_valid <= 1'b0;
    else if (emit_go)    out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (emit_go) begin
      if (blank) begin
        pixel_x     <= '0;
        pixel_y     <= '0;
        pixel_index <= '0;
        visible     <= 1'b0;
        valid_pixel <= 1'b0;
        last        <= 1'b0;
      end else begin
        pixel_x     <= cursor_x;
        pixel_y     <= cursor_y;
        pixel_index <= lin_visible ? lin[INDEX_BITS-1:0] : '0;
        visible     <= lin_visible;
        valid_pixel <= 1'b1;
        last        <= at_end;
      end
    end
  end

  `RSL_ASSERT(a_div_start_free, div_req.start |-> !div_rsp.busy, "divider started while busy")
  `RSL_ASSERT_NEXT(a_last_ends_segment, emit_go && !blank && at_end, !segment_active, "segment stays active after its end point")
  `RSL_ASSERT(a_hidden_index_zero, out_valid && !visible |-> pixel_index == '0, "hidden pixel carries an index")
  `RSL_ASSERT(a_blank_result_zero, out_valid && !valid_pixel |-> !visible && !last && pixel_x == '0 && pixel_y == '0, "blank result not all zero")

endmodule

// ===== sv/rsl_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on rsl_pkg for widths and the request and response structs.
module rsl_divider import rsl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                     busy;
  logic                     done;
  logic [STEP_CNT_BITS-1:0] count;
  ext_t                     rem;
  ext_t                     dvsr;
  ratio_t                   quo;
  logic [COORD_BITS:0]      trial;
  logic [COORD_BITS:0]      diff;
  logic                     fits;

  // Shift in the next dividend bit and trial subtract
  assign trial = {rem, quo[RATIO_BITS-1]};
  assign diff  = trial - {1'b0, dvsr};
  assign fits  = trial >= {1'b0, dvsr};

  // Control: step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        if (count == STEP_CNT_BITS'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        count <= count + 1'b1;
      end
    end
  end

  // Datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quo  <= req.dividend;
      dvsr <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      quo <= {quo[RATIO_BITS-2:0], fits};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== tb/ratio_step_line_rasterizer_tb.sv =====
// Self-checking testbench for the ratio step line rasterizer.
// Needs rsl_pkg and the ratio_step_line_rasterizer RTL; drives a stimulus table, then random
// segments, and checks every pixel item against its segment walker or a pinned value.
module ratio_step_line_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rsl_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int RAND_ITEMS = 1200;
  localparam int LONG_HOLD  = 600;
  localparam int QUIET_MAX  = 4000;
  localparam int TAIL_WAIT  = 120;

  typedef struct packed {
    coord_t px;
    coord_t py;
    index_t idx;
    logic   vis;
    logic   vp;
    logic   lst;
  } pixel_t;

  typedef struct {
    logic   m;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    bit     fixed;
    pixel_t fixed_pix;
  } stim_row_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_stall;
  logic   mode = MODE_LOAD;
  coord_t start_x = '0;
  coord_t start_y = '0;
  coord_t end_x = '0;
  coord_t end_y = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  coord_t pixel_x;
  coord_t pixel_y;
  index_t pixel_index;
  logic   visible;
  logic   valid_pixel;
  logic   last;

  // Walker state: latched endpoints, cursor, major axis, ratio, activity
  int org_x, org_y, tgt_x, tgt_y, cur_x, cur_y;
  bit x_major;
  int seg_ratio;
  bit seg_active;

  pixel_t    pixel_q[$];
  stim_row_t dir_rows[$];

  int sent, n_loads, results_seen, mismatches;
  int n_ends, n_hidden, n_idle;
  bit squeezed;

  ratio_step_line_rasterizer i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .pixel_index(pixel_index),
    .visible    (visible),
    .valid_pixel(valid_pixel),
    .last       (last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int span(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int dir_of(int from, int to);
    return (to > from) ? 1 : ((to < from) ? -1 : 0);
  endfunction

  function automatic coord_t clamp_coord(int v);
    if (v < -4096) return coord_t'(-4096);
    if (v > 4095) return coord_t'(4095);
    return coord_t'(v);
  endfunction

  // Most gaps short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Build the pixel item at the cursor, with its linear index and visibility
  function automatic pixel_t place_pixel(bit at_end);
    longint lin;
    pixel_t p;
    lin = longint'(cur_y) * FRAME_WIDTH + cur_x;
    p.px  = coord_t'(cur_x);
    p.py  = coord_t'(cur_y);
    p.vis = (lin >= 0) && (lin < FRAME_WIDTH * FRAME_HEIGHT);
    p.idx = p.vis ? index_t'(lin) : '0;
    p.vp  = 1'b1;
    p.lst = at_end;
    return p;
  endfunction

  // Advance the walker by one item and return the pixel it yields
  function automatic pixel_t trace_step(logic m, coord_t sx, coord_t sy,
                                        coord_t ex, coord_t ey);
    int major_ext, minor_ext, major_trav, minor_trav;
    bit at_end;
    if (m == MODE_LOAD) begin
      org_x = sx;
      org_y = sy;
      tgt_x = ex;
      tgt_y = ey;
      cur_x = org_x;
      cur_y = org_y;
      x_major = span(tgt_x, org_x) > span(tgt_y, org_y);
      major_ext = x_major ? span(tgt_x, org_x) : span(tgt_y, org_y);
      minor_ext = x_major ? span(tgt_y, org_y) : span(tgt_x, org_x);
      seg_ratio = (major_ext != 0) ? (RATIO_SCALE * minor_ext) / major_ext : 0;
      at_end = (cur_x == tgt_x) && (cur_y == tgt_y);
      seg_active = !at_end;
      return place_pixel(at_end);
    end
    if (!seg_active) return '0;
    // Step the major axis, then catch the minor axis up to the ratio
    if (x_major) cur_x += dir_of(org_x, tgt_x);
    else cur_y += dir_of(org_y, tgt_y);
    major_trav = x_major ? span(cur_x, org_x) : span(cur_y, org_y);
    minor_ext  = x_major ? span(tgt_y, org_y) : span(tgt_x, org_x);
    minor_trav = x_major ? span(cur_y, org_y) : span(cur_x, org_x);
    while (major_trav != 0 && minor_trav < minor_ext &&
           (RATIO_SCALE * minor_trav) / major_trav < seg_ratio) begin
      if (x_major) cur_y += dir_of(org_y, tgt_y);
      else cur_x += dir_of(org_x, tgt_x);
      minor_trav++;
    end
    at_end = (cur_x == tgt_x) && (cur_y == tgt_y);
    if (at_end) seg_active = 1'b0;
    return place_pixel(at_end);
  endfunction

  function automatic stim_row_t load_row(int sx, int sy, int ex, int ey);
    stim_row_t r;
    r.m  = MODE_LOAD;
    r.sx = coord_t'(sx);
    r.sy = coord_t'(sy);
    r.ex = coord_t'(ex);
    r.ey = coord_t'(ey);
    r.fixed = 1'b0;
    r.fixed_pix = '0;
    return r;
  endfunction

  // Advance item; the endpoint fields are don't-care, so fill them at random
  function automatic stim_row_t adv_row();
    stim_row_t r;
    r = load_row($urandom, $urandom, $urandom, $urandom);
    r.m = MODE_ADVANCE;
    return r;
  endfunction

  function automatic stim_row_t pin(stim_row_t r, int px, int py, int idx,
                                    bit vis, bit vp, bit lst);
    r.fixed = 1'b1;
    r.fixed_pix.px  = coord_t'(px);
    r.fixed_pix.py  = coord_t'(py);
    r.fixed_pix.idx = index_t'(idx);
    r.fixed_pix.vis = vis;
    r.fixed_pix.vp  = vp;
    r.fixed_pix.lst = lst;
    return r;
  endfunction

  // Offer one item, hold it until taken, record its expected pixel
  task automatic send_item(stim_row_t r);
    pixel_t guess;
    int gap;
    mode     <= r.m;
    start_x  <= r.sx;
    start_y  <= r.sy;
    end_x    <= r.ex;
    end_y    <= r.ey;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    guess = trace_step(r.m, r.sx, r.sy, r.ex, r.ey);
    pixel_q.push_back(r.fixed ? r.fixed_pix : guess);
    sent++;
    if (r.m == MODE_LOAD) n_loads++;
    gap = ((sent % 256) < 48) ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver: random stall bursts, long free stretches, one long hold-off
  initial begin : rx_side
    int ready_len, stall_len;
    @(posedge clk iff !rst);
    forever begin
      if (!squeezed && results_seen >= 200) begin
        squeezed = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      ready_len = ($urandom_range(0, 19) == 0) ? $urandom_range(150, 300)
                                               : $urandom_range(1, 8);
      stall_len = pick_gap();
      out_stall <= 1'b0;
      repeat (ready_len) @(posedge clk);
      if (stall_len != 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // Compare each taken pixel item with the oldest expectation
  always @(posedge clk) begin : check_pixels
    pixel_t seen, want;
    if (!rst && out_valid && !out_stall) begin
      seen = '{pixel_x, pixel_y, pixel_index, visible, valid_pixel, last};
      results_seen++;
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected pixel x=%0d y=%0d with nothing pending",
                   seen.px, seen.py);
      end else begin
        want = pixel_q.pop_front();
        if (seen.px !== want.px || seen.py !== want.py || seen.idx !== want.idx ||
            seen.vis !== want.vis || seen.vp !== want.vp || seen.lst !== want.lst) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("tb: pixel %0d expected x=%0d y=%0d idx=%0d vis=%0b vp=%0b last=%0b",
                     results_seen, want.px, want.py, want.idx, want.vis, want.vp,
                     want.lst);
            $display("tb: pixel %0d got      x=%0d y=%0d idx=%0d vis=%0b vp=%0b last=%0b",
                     results_seen, seen.px, seen.py, seen.idx, seen.vis, seen.vp,
                     seen.lst);
          end
        end
        n_ends   += want.lst;
        n_hidden += (want.vp && !want.vis);
        n_idle   += !want.vp;
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_MAX) begin
      $display("tb: no handshake for %0d cycles, %0d pixels pending", quiet, pixel_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : main
    int sel, ox, oy, dx, dy, maj, steps;
    stim_row_t r;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table: idle advance, extremes, frame edges, each axis case
    dir_rows.push_back(pin(adv_row(), 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(pin(load_row(0, 0, 0, 0), 0, 0, 0, 1, 1, 1));
    dir_rows.push_back(pin(adv_row(), 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(pin(load_row(1919, 1079, 1919, 1079), 1919, 1079, 2073599, 1, 1, 1));
    dir_rows.push_back(pin(load_row(-4096, -4096, -4096, -4096), -4096, -4096, 0, 0, 1, 1));
    dir_rows.push_back(pin(load_row(4095, 4095, 4095, 4095), 4095, 4095, 0, 0, 1, 1));
    dir_rows.push_back(pin(load_row(1920, 0, 1920, 0), 1920, 0, 1920, 1, 1, 1));
    dir_rows.push_back(load_row(-1, 1, -1, 1));
    dir_rows.push_back(load_row(0, 0, 5, 2));
    repeat (5) dir_rows.push_back(adv_row());
    dir_rows.push_back(load_row(0, 0, 2, 5));
    repeat (2) dir_rows.push_back(adv_row());
    dir_rows.push_back(load_row(3, 3, 0, 0));
    repeat (3) dir_rows.push_back(adv_row());
    dir_rows.push_back(load_row(-4096, 4095, 4095, -4096));
    repeat (2) dir_rows.push_back(adv_row());
    dir_rows.push_back(load_row(10, -5, 13, -5));
    repeat (4) dir_rows.push_back(adv_row());
    foreach (dir_rows[i]) send_item(dir_rows[i]);

    // Random part: mostly whole segments walked to the end, some noise
    while (sent < RAND_ITEMS + dir_rows.size()) begin
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
          ox = $urandom_range(0, 1919);
          oy = $urandom_range(0, 1079);
        end else if (sel < 8) begin
          ox = ($urandom_range(0, 1) ? 1900 : -20) + int'($urandom_range(0, 40));
          oy = ($urandom_range(0, 1) ? 1060 : -20) + int'($urandom_range(0, 40));
        end else begin
          ox = int'(coord_t'($urandom));
          oy = int'(coord_t'($urandom));
        end
        sel = $urandom_range(0, 99);
        if (sel < 85) begin
          dx = int'($urandom_range(0, 24)) - 12;
          dy = int'($urandom_range(0, 24)) - 12;
        end else if (sel < 97) begin
          dx = int'($urandom_range(0, 240)) - 120;
          dy = int'($urandom_range(0, 240)) - 120;
        end else begin
          dx = int'(coord_t'($urandom)) - ox;
          dy = int'(coord_t'($urandom)) - oy;
        end
        r = load_row(ox, oy, clamp_coord(ox + dx), clamp_coord(oy + dy));
        maj = span(int'(r.ex), ox) > span(int'(r.ey), oy) ? span(int'(r.ex), ox)
                                                            : span(int'(r.ey), oy);
        // Cut some segments short so a new load drops them
        steps = ($urandom_range(0, 9) == 0 || maj > 150) ? $urandom_range(0, 30) : maj;
        if (steps > maj) steps = maj;
        send_item(r);
        repeat (steps) send_item(adv_row());
        if ($urandom_range(0, 99) < 15) send_item(adv_row());
      end else begin
        r = adv_row();
        r.m = $urandom_range(0, 1);
        send_item(r);
      end
    end

    // Drain: wait for every pixel, then let the block settle
    @(posedge clk);
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("tb: drove %0d items (%0d loads, %0d advances), one %0d-cycle output hold-off",
             sent, n_loads, sent - n_loads, LONG_HOLD);
    $display("tb: checked %0d pixels: %0d segment ends, %0d off-frame, %0d idle advances",
             results_seen, n_ends, n_hidden, n_idle);
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches, %0d pixels pending", mismatches, pixel_q.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
